### rtl/core/trp_pkg.sv
// Types and codes shared by the task picker modules.
`default_nettype none

package trp_pkg;

    localparam int OP_W      = 3;
    localparam int SLOT_IN_W = 5;
    localparam int STAT_W    = 2;

    localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_HIGH = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_LOW  = 3'd2;
    localparam logic [OP_W-1:0] OP_KILL     = 3'd3;
    localparam logic [OP_W-1:0] OP_STOPPED  = 3'd4;
    localparam logic [OP_W-1:0] OP_ENDED    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_LIVE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE_LEFT = 2'd3;

    localparam logic PRIO_LO = 1'b0;
    localparam logic PRIO_HI = 1'b1;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [SLOT_IN_W-1:0] slot_out;
        logic                 kill_valid;
        logic                 resume_valid;
        logic [SLOT_IN_W-1:0] resume_slot;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/trp_if.sv
// Valid/ready channels for task events and picker results.
`default_nettype none

interface trp_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [4:0] slot;

    modport source (output valid, output opcode, output slot, input ready);
    modport sink   (input valid, input opcode, input slot, output ready);
endinterface

interface trp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] slot_out;
    logic       kill_valid;
    logic       resume_valid;
    logic [4:0] resume_slot;

    modport source (output valid, output status, output slot_out, output kill_valid,
                    output resume_valid, output resume_slot, input ready);
    modport sink   (input valid, input status, input slot_out, input kill_valid,
                    input resume_valid, input resume_slot, output ready);
endinterface

`default_nettype wire

### rtl/core/trp_first.sv
// Find-first-set encoder, lowest bit wins.
`default_nettype none

module trp_first #(
    parameter int W = 64
) (
    input  wire logic [W-1:0]         i_vec,
    output logic                      o_found,
    output logic [$clog2(W)-1:0]      o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = ($clog2(W))'(i);
            end
        end
        o_found = |i_vec;
    end

endmodule

`default_nettype wire

### rtl/core/trp_pick.sv
// Round-robin next-slot search: live high-priority first, then any live slot.
`default_nettype none

module trp_pick #(
    parameter int SLOTS = 32
) (
    input  wire logic [SLOTS-1:0]         i_live,
    input  wire logic [SLOTS-1:0]         i_high,
    input  wire logic [$clog2(SLOTS)-1:0] i_run,
    output logic                          o_found,
    output logic [$clog2(SLOTS)-1:0]      o_slot
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DBL_W  = SLOT_W + 1;

    logic [SLOTS-1:0]   upper;
    logic [SLOTS-1:0]   hi_req;
    logic               found_h;
    logic               found_l;
    logic [DBL_W-1:0]   idx_h;
    logic [DBL_W-1:0]   idx_l;
    logic [DBL_W-1:0]   idx;

    // slots strictly after the running one come first, then the wrap
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            upper[i] = (DBL_W'(i) > {1'b0, i_run});
        end
    end

    assign hi_req = i_live & i_high;

    trp_first #(.W(2 * SLOTS)) u_first_high (
        .i_vec   ({hi_req, hi_req & upper}),
        .o_found (found_h),
        .o_idx   (idx_h)
    );

    trp_first #(.W(2 * SLOTS)) u_first_live (
        .i_vec   ({i_live, i_live & upper}),
        .o_found (found_l),
        .o_idx   (idx_l)
    );

    always_comb begin
        idx     = found_h ? idx_h : idx_l;
        o_found = found_h | found_l;
        if (idx >= DBL_W'(SLOTS)) begin
            o_slot = SLOT_W'(idx - DBL_W'(SLOTS));
        end else begin
            o_slot = SLOT_W'(idx);
        end
    end

endmodule

`default_nettype wire

### rtl/core/trp_engine.sv
// Slot state (live, priority, running) and per-event decode.
`default_nettype none

module trp_engine
    import trp_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [OP_W-1:0]      i_opcode,
    input  wire logic [SLOT_IN_W-1:0] i_slot,
    output t_result                   o_result
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CMP_W  = ((SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W) + 1;

    logic [SLOTS-1:0]  r_live;
    logic [SLOTS-1:0]  r_high;
    logic [SLOT_W-1:0] r_run;
    logic [SLOTS-1:0]  n_live;
    logic [SLOTS-1:0]  n_high;
    logic [SLOT_W-1:0] n_run;

    logic [SLOTS-1:0]  sel;
    logic [SLOTS-1:0]  search_live;
    logic              live_hit;
    logic              is_running;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              pick_found;
    logic [SLOT_W-1:0] pick_slot;

    // one-hot of the addressed slot; slots beyond SLOTS simply never match
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            sel[i] = (CMP_W'(i) == CMP_W'(i_slot));
        end
    end

    assign live_hit    = |(r_live & sel);
    assign is_running  = (CMP_W'(r_run) == CMP_W'(i_slot));
    assign search_live = (i_opcode == OP_ENDED) ? (r_live & ~sel) : r_live;

    trp_first #(.W(SLOTS)) u_free (
        .i_vec   (~r_live),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    trp_pick #(.SLOTS(SLOTS)) u_pick (
        .i_live  (search_live),
        .i_high  (r_high),
        .i_run   (r_run),
        .o_found (pick_found),
        .o_slot  (pick_slot)
    );

    always_comb begin
        n_live   = r_live;
        n_high   = r_high;
        n_run    = r_run;
        o_result = '0;
        case (i_opcode)
            OP_CREATE: begin
                if (free_found) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (SLOT_W'(i) == free_idx) begin
                            n_live[i] = 1'b1;
                            n_high[i] = PRIO_LO;
                        end
                    end
                    o_result.slot_out = SLOT_IN_W'(free_idx);
                end else begin
                    o_result.status = ST_NO_FREE;
                end
            end
            OP_SET_HIGH: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (sel[i]) n_high[i] = PRIO_HI;
                end
            end
            OP_SET_LOW: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (sel[i]) n_high[i] = PRIO_LO;
                end
            end
            OP_KILL: begin
                if (live_hit) begin
                    o_result.kill_valid = 1'b1;
                    o_result.slot_out   = i_slot;
                end else begin
                    o_result.status = ST_NOT_LIVE;
                end
            end
            OP_STOPPED, OP_ENDED: begin
                n_live = search_live;
                if (is_running) begin
                    if (pick_found) begin
                        n_run                 = pick_slot;
                        o_result.resume_valid = 1'b1;
                        o_result.resume_slot  = SLOT_IN_W'(pick_slot);
                    end else begin
                        o_result.status = ST_NONE_LEFT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_high <= '0;
            r_run  <= '0;
        end else if (i_fire) begin
            r_live <= n_live;
            r_high <= n_high;
            r_run  <= n_run;
        end
    end

endmodule

`default_nettype wire

### rtl/core/two_level_round_robin_task_picker.sv
// Top level of the two-level round-robin task picker.
//
//   channel    dir  fields
//   i_task     in   opcode[2:0], slot[4:0]
//   o_result   out  status[1:0], slot_out[4:0], kill_valid, resume_valid, resume_slot[4:0]
//
// One event per cycle sustained while o_result.ready holds; a taken event passes
// through the input register and then the result register, the slot search being a
// rotated find-first over the live mask between the two.
// Synchronous reset clears the live and priority bits, the running slot and
// both valid flags. A stalled result holds in its register while one more
// beat waits in the input register.
`default_nettype none

module two_level_round_robin_task_picker
    import trp_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    trp_in_if.sink     i_task,
    trp_out_if.source  o_result
);

    logic                 r_in_valid;
    logic [OP_W-1:0]      r_opcode;
    logic [SLOT_IN_W-1:0] r_slot;
    logic                 r_res_valid;
    t_result              r_res;
    t_result              n_res;
    logic                 res_free;
    logic                 advance;

    assign res_free     = !r_res_valid || o_result.ready;
    assign advance      = r_in_valid && res_free;
    assign i_task.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_task.ready) begin
            r_in_valid <= i_task.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_task.ready && i_task.valid) begin
            r_opcode <= i_task.opcode;
            r_slot   <= i_task.slot;
        end
    end

    trp_engine #(.SLOTS(SLOTS)) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_opcode (r_opcode),
        .i_slot   (r_slot),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_free) begin
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid        = r_res_valid;
    assign o_result.status       = r_res.status;
    assign o_result.slot_out     = r_res.slot_out;
    assign o_result.kill_valid   = r_res.kill_valid;
    assign o_result.resume_valid = r_res.resume_valid;
    assign o_result.resume_slot  = r_res.resume_slot;

endmodule

`default_nettype wire

### tb/two_level_round_robin_task_picker_test.sv
// Self-checking testbench for the two-level round-robin task picker.
`timescale 1ns / 1ps

module two_level_round_robin_task_picker_test;
    import trp_pkg::*;

    localparam int PICK_SLOTS  = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 325;

    // codes the block must ignore
    localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [SLOT_IN_W-1:0] slot;
    } t_task_beat;

    typedef struct packed {
        logic [PICK_SLOTS-1:0] live;
        logic [PICK_SLOTS-1:0] high;
        logic [SLOT_IN_W-1:0]  running;
    } t_sched_state;

    logic i_clk;
    logic i_rst_n;

    trp_in_if  task_ch ();
    trp_out_if result_ch ();

    two_level_round_robin_task_picker #(
        .SLOTS(PICK_SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (task_ch),
        .o_result(result_ch)
    );

    t_task_beat   pending_beats[$];
    t_result      expected_results[$];
    t_sched_state gen_state;     // state as seen by the stimulus generator
    t_sched_state sched_state;   // state as seen at acceptance
    t_task_beat   head_beat;
    t_result      got_result;
    t_result      want_result;

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int mismatches;
    int results_checked;
    int kills_seen, resumes_seen, none_left_seen, no_free_seen, not_live_seen;

    // One scheduler event: returns the result and the state after it.
    function automatic t_result sched_event(input t_sched_state cur, input t_task_beat b,
                                            output t_sched_state nxt);
        t_result res;
        logic found;
        logic do_pick;
        logic [SLOT_IN_W-1:0] idx;
        res = '0;
        nxt = cur;
        found = 1'b0;
        do_pick = 1'b0;
        case (b.opcode)
            OP_CREATE: begin
                for (int i = 0; i < PICK_SLOTS; i++) begin
                    if (!found && !nxt.live[i]) begin
                        nxt.live[i] = 1'b1;
                        nxt.high[i] = PRIO_LO;
                        res.slot_out = SLOT_IN_W'(i);
                        found = 1'b1;
                    end
                end
                if (!found) res.status = ST_NO_FREE;
            end
            OP_SET_HIGH: nxt.high[b.slot] = PRIO_HI;
            OP_SET_LOW:  nxt.high[b.slot] = PRIO_LO;
            OP_KILL: begin
                if (cur.live[b.slot]) begin
                    res.kill_valid = 1'b1;
                    res.slot_out = b.slot;
                end else begin
                    res.status = ST_NOT_LIVE;
                end
            end
            OP_STOPPED: do_pick = (b.slot == cur.running);
            OP_ENDED: begin
                nxt.live[b.slot] = 1'b0;
                do_pick = (b.slot == cur.running);
            end
            default: ;
        endcase
        if (do_pick) begin
            // high-priority pass first, then any live slot; search wraps to running
            for (int k = 1; k <= PICK_SLOTS; k++) begin
                idx = nxt.running + SLOT_IN_W'(k);
                if (!found && nxt.live[idx] && nxt.high[idx]) begin
                    res.resume_slot = idx;
                    found = 1'b1;
                end
            end
            for (int k = 1; k <= PICK_SLOTS; k++) begin
                idx = nxt.running + SLOT_IN_W'(k);
                if (!found && nxt.live[idx]) begin
                    res.resume_slot = idx;
                    found = 1'b1;
                end
            end
            if (found) begin
                res.resume_valid = 1'b1;
                nxt.running = res.resume_slot;
            end else begin
                res.status = ST_NONE_LEFT;
            end
        end
        return res;
    endfunction

    task automatic queue_beat(input logic [OP_W-1:0] op, input logic [SLOT_IN_W-1:0] slot);
        t_task_beat b;
        b.opcode = op;
        b.slot = slot;
        pending_beats.push_back(b);
        void'(sched_event(gen_state, b, gen_state));
    endtask

    // Mostly meaningful events: slots that are live or running, with
    // create-heavy stretches so the table fills up now and then.
    task automatic queue_random_beats(input int count);
        int roll;
        int create_pct;
        int offset;
        logic [OP_W-1:0]      op;
        logic [SLOT_IN_W-1:0] slot;
        logic [SLOT_IN_W-1:0] probe;
        logic found;
        create_pct = 65;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39)
                create_pct = ($urandom_range(3) == 0) ? 70 : $urandom_range(30, 8);
            roll = $urandom_range(99);
            if (roll < create_pct) begin
                op = OP_CREATE;
            end else begin
                roll = $urandom_range(99);
                if (roll < 3)       op = ($urandom_range(1) == 0) ? OP_UNDEF_6 : OP_UNDEF_7;
                else if (roll < 18) op = OP_SET_HIGH;
                else if (roll < 30) op = OP_SET_LOW;
                else if (roll < 48) op = OP_KILL;
                else if (roll < 74) op = OP_STOPPED;
                else                op = OP_ENDED;
            end
            slot = SLOT_IN_W'($urandom_range(31));
            roll = $urandom_range(99);
            if ((op == OP_STOPPED || op == OP_ENDED) && roll < 55) begin
                slot = gen_state.running;
            end else if (roll < 80 && gen_state.live != '0) begin
                offset = $urandom_range(31);
                found = 1'b0;
                for (int k = 0; k < PICK_SLOTS; k++) begin
                    probe = SLOT_IN_W'(offset + k);
                    if (!found && gen_state.live[probe]) begin
                        slot = probe;
                        found = 1'b1;
                    end
                end
            end
            queue_beat(op, slot);
        end
    endtask

    always #1 i_clk = ~i_clk;

    // Driver: presents queued beats, records the expected result on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            task_ch.valid <= 1'b0;
        end else begin
            if (task_ch.valid && task_ch.ready) begin
                expected_results.push_back(
                    sched_event(sched_state, t_task_beat'({task_ch.opcode, task_ch.slot}),
                                sched_state));
            end
            if (!task_ch.valid || task_ch.ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    head_beat = pending_beats.pop_front();
                    task_ch.valid  <= 1'b1;
                    task_ch.opcode <= head_beat.opcode;
                    task_ch.slot   <= head_beat.slot;
                end else begin
                    task_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, checks each result beat in order.
    always @(posedge i_clk) begin
        cycle_count++;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got_result = '{status: result_ch.status, slot_out: result_ch.slot_out,
                               kill_valid: result_ch.kill_valid,
                               resume_valid: result_ch.resume_valid,
                               resume_slot: result_ch.resume_slot};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat %p at cycle %0d",
                                 got_result, cycle_count);
                end else begin
                    want_result = expected_results.pop_front();
                    results_checked++;
                    if (want_result.kill_valid)   kills_seen++;
                    if (want_result.resume_valid) resumes_seen++;
                    case (want_result.status)
                        ST_NONE_LEFT: none_left_seen++;
                        ST_NO_FREE:   no_free_seen++;
                        ST_NOT_LIVE:  not_live_seen++;
                        default: ;
                    endcase
                    if (got_result.status !== want_result.status
                            || got_result.slot_out !== want_result.slot_out
                            || got_result.kill_valid !== want_result.kill_valid
                            || got_result.resume_valid !== want_result.resume_valid
                            || got_result.resume_slot !== want_result.resume_slot) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d expected %p got %p",
                                     results_checked, want_result, got_result);
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        task_ch.valid = 1'b0;
        task_ch.opcode = OP_CREATE;
        task_ch.slot = '0;
        result_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        mismatches = 0;
        results_checked = 0;
        kills_seen = 0;
        resumes_seen = 0;
        none_left_seen = 0;
        no_free_seen = 0;
        not_live_seen = 0;
        gen_state = '0;
        sched_state = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (ph == 0) begin
                queue_beat(OP_STOPPED, 5'd0);   // running slot not live, nothing to pick
                queue_beat(OP_ENDED, 5'd0);
                queue_beat(OP_KILL, 5'd5);      // dead slot
                queue_beat(OP_SET_HIGH, 5'd3);  // dead slot, bit still written
                queue_beat(OP_CREATE, 5'd31);
                queue_beat(OP_CREATE, 5'd0);
                queue_beat(OP_CREATE, 5'd17);
                queue_beat(OP_CREATE, 5'd9);    // create forces low priority
                queue_beat(OP_SET_HIGH, 5'd2);
                queue_beat(OP_STOPPED, 5'd0);   // high slot wins
                queue_beat(OP_STOPPED, 5'd1);   // not running
                queue_beat(OP_KILL, 5'd2);
                queue_beat(OP_SET_LOW, 5'd2);
                queue_beat(OP_STOPPED, 5'd2);
                queue_beat(OP_ENDED, 5'd1);     // not running, still cleared
                queue_beat(OP_ENDED, 5'd3);     // search wraps past the top
                queue_beat(OP_UNDEF_6, 5'd31);
                queue_beat(OP_UNDEF_7, 5'd17);
                queue_beat(OP_SET_HIGH, 5'd31);
                queue_beat(OP_ENDED, 5'd0);
                queue_beat(OP_ENDED, 5'd2);     // last live task gone
                queue_beat(OP_CREATE, 5'd0);
                queue_beat(OP_KILL, 5'd31);
            end
            queue_random_beats(RANDOM_PER_PHASE);
            while (pending_beats.size() != 0 || task_ch.valid
                    || expected_results.size() != 0)
                @(negedge i_clk);
        end

        repeat (8) @(negedge i_clk);
        $display("Checked %0d results over four backpressure phases: %0d kills, %0d resumes,",
                 results_checked, kills_seen, resumes_seen);
        $display("%0d with no task left, %0d with the table full, %0d on dead slots",
                 none_left_seen, no_free_seen, not_live_seen);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/trp_pkg.sv
rtl/core/trp_if.sv
rtl/core/trp_first.sv
rtl/core/trp_pick.sv
rtl/core/trp_engine.sv
rtl/core/two_level_round_robin_task_picker.sv
tb/two_level_round_robin_task_picker_test.sv
